>>> design/trs_pkg.sv
// ----------------------------------------------------------------------------
// trs_pkg: shared types, constants and helpers of the tile resampler
// Register indexes, resampling modes, sequencer states and the per-axis
// position, tap and weight helpers used by the top level.
// ----------------------------------------------------------------------------
package trs_pkg;

	localparam int COL_W  = 7;
	localparam int ROW_W  = 7;
	localparam int BAND_W = 2;
	localparam int ADDR_W = ROW_W + COL_W + BAND_W;
	localparam int DEPTH  = 1 << ADDR_W;
	localparam int SAMP_W = 16;
	localparam int LOC_W  = 26;
	localparam int PRD_W  = 30;
	localparam int MUL_W  = 47;
	localparam int ACC_W  = 50;

	localparam logic [2:0] REG_MODE   = 3'd0;
	localparam logic [2:0] REG_WIDTH  = 3'd1;
	localparam logic [2:0] REG_HEIGHT = 3'd2;
	localparam logic [2:0] REG_BANDS  = 3'd3;
	localparam logic [2:0] REG_ORG_X  = 3'd4;
	localparam logic [2:0] REG_ORG_Y  = 3'd5;
	localparam logic [2:0] REG_NODATA = 3'd6;

	typedef enum logic [1:0] {
		MODE_NEAREST,
		MODE_BILINEAR,
		MODE_CUBIC,
		MODE_NONE
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_AXIS,
		ST_POW,
		ST_WGT,
		ST_PROD,
		ST_TAP,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic       ok;
		logic [6:0] base;
		logic [7:0] frac;
	} axis_t;

	// Range check, base index and fraction of one axis for the given mode.
	function automatic axis_t axis_setup(input logic signed [LOC_W-1:0] l,
		input logic [7:0] s, input mode_t m);
		logic signed [LOC_W-1:0] s256;
		logic signed [LOC_W-1:0] t;
		logic signed [LOC_W-1:0] hi;
		logic signed [LOC_W-1:0] c;
		axis_t r;
		s256 = $signed({10'b0, s, 8'b0});
		t = '0;
		hi = '0;
		c = '0;
		r = '0;
		unique case (m)
			MODE_NEAREST: begin
				t = l + 26'sd128;
				r.ok = (t > -26'sd256) && (t < s256);
				r.base = t[LOC_W-1] ? 7'd0 : t[14:8];
			end
			MODE_BILINEAR: begin
				r.ok = (l >= -26'sd128) && (l < s256 + 26'sd128);
				hi = s256 - 26'sd257;
				c = (l > hi) ? hi : l;
				c = c[LOC_W-1] ? '0 : c;
				r.base = c[14:8];
				r.frac = c[7:0];
			end
			MODE_CUBIC: begin
				r.ok = !l[LOC_W-1] && (l <= s256 - 26'sd256);
				r.base = l[14:8];
				r.frac = l[7:0];
			end
			MODE_NONE: begin
				r.ok = 1'b0;
			end
		endcase
		return r;
	endfunction

	// Neighbor index base + k (minus one for cubic), clamped to the tile.
	function automatic logic [6:0] tap_coord(input logic [6:0] base, input logic [1:0] k,
		input logic cub, input logic [7:0] s);
		logic signed [9:0] c;
		logic signed [9:0] top;
		c = $signed({3'b0, base}) + $signed({8'b0, k}) - $signed({9'b0, cub});
		top = $signed({2'b0, s}) - 10'sd1;
		if (c < 10'sd0) begin
			c = '0;
		end else if (c > top) begin
			c = top;
		end
		return c[6:0];
	endfunction

	// Q1.14 weight of tap k; the cubic terms are the Catmull-Rom polynomials
	// scaled so that rounding needs only an 11-bit shift.
	function automatic logic signed [15:0] tap_weight(input mode_t m, input logic [7:0] f,
		input logic [15:0] f2, input logic [23:0] f3, input logic [1:0] k);
		logic signed [28:0] sf;
		logic signed [28:0] sf2;
		logic signed [28:0] sf3;
		logic signed [28:0] p;
		logic signed [15:0] u;
		logic signed [15:0] w;
		sf = $signed({21'b0, f});
		sf2 = $signed({13'b0, f2});
		sf3 = $signed({5'b0, f3});
		u = $signed({2'b0, f, 6'b0});
		p = '0;
		w = '0;
		unique case (m)
			MODE_NEAREST: begin
				w = (k == 2'd0) ? 16'sd16384 : 16'sd0;
			end
			MODE_BILINEAR: begin
				if (k == 2'd0) begin
					w = 16'sd16384 - u;
				end else if (k == 2'd1) begin
					w = u;
				end
			end
			MODE_CUBIC: begin
				case (k)
					2'd0: p = (sf2 <<< 9) - sf3 - (sf <<< 16);
					2'd1: p = (sf3 <<< 1) + sf3 - (sf2 <<< 10) - (sf2 <<< 8)
						+ 29'sd33554432;
					2'd2: p = (sf2 <<< 10) + (sf <<< 16) - (sf3 <<< 1) - sf3;
					default: p = sf3 - (sf2 <<< 8);
				endcase
				p = p + 29'sd1024;
				w = p[26:11];
			end
			MODE_NONE: begin
				w = '0;
			end
		endcase
		return w;
	endfunction

endpackage

>>> design/trs_ram.sv
// ----------------------------------------------------------------------------
// trs_ram: generic single-port RAM
// One write or one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module trs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

>>> design/tile_resample_interpolator_top.sv
// ----------------------------------------------------------------------------
// tile_resample_interpolator_top: multi-band tile store with point resampler
// Stores source samples and answers resampling queries one band at a time.
// ----------------------------------------------------------------------------
// Usage. An item is taken at a clock edge where start is high and busy is low.
// With cmd low the item writes sample_value into the tile store at
// (write_row, write_col, write_band) and gives no result.
// With cmd high the item is a query at (src_x, src_y) in signed Q15.8; one
// result per band comes out, each on pixel_value, band_index and last_band for
// exactly one cycle while strobe is high. The receiver cannot hold results off.
// Steps of a query with N taps per axis (1 nearest, 2 bilinear, 4 cubic):
// axis setup, the fraction powers and the tap weights, N*N weight products,
// then per band N*N reads of the single-port tile memory, one tap read per
// cycle, a multiply-accumulate drain and one output. Queries outside the
// tile, or in the unused mode, skip the reads and give nodata_value at one
// result per cycle. Configuration is written through cfg_we, cfg_index and
// cfg_data; the user must do this only while busy is low, as the block does
// not enforce it. Reset restores the register defaults; the tile store is
// not cleared and must be written first.
// ----------------------------------------------------------------------------
module tile_resample_interpolator_top import trs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               cmd,
	input  logic [COL_W-1:0]   write_col,
	input  logic [ROW_W-1:0]   write_row,
	input  logic [BAND_W-1:0]  write_band,
	input  logic signed [15:0] sample_value,
	input  logic signed [23:0] src_x,
	input  logic signed [23:0] src_y,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output logic               strobe,
	output logic signed [15:0] pixel_value,
	output logic [BAND_W-1:0]  band_index,
	output logic               last_band
);

	// Configuration registers.
	mode_t              mode_q;
	logic [7:0]         width_q;
	logic [7:0]         height_q;
	logic [2:0]         bands_q;
	logic [15:0]        org_x_q;
	logic [15:0]        org_y_q;
	logic signed [15:0] nodata_q;

	// Sequencer.
	state_t      state_q, state_d;
	logic [1:0]  pow_q;
	logic [1:0]  ti_q, tj_q;
	logic [1:0]  nlast_q;
	logic [1:0]  bq_q;
	logic        rd_v_s1, mul_v_s2;
	logic        strobe_q;

	// Query datapath.
	logic signed [LOC_W-1:0] lx_q, ly_q;
	logic                    inside_q;
	logic [6:0]              basex_q, basey_q;
	logic [7:0]              fx_q, fy_q;
	logic [15:0]             f2x_q, f2y_q;
	logic [23:0]             f3x_q, f3y_q;
	logic signed [15:0]      wx_q [4];
	logic signed [15:0]      wy_q [4];
	logic signed [PRD_W-1:0] wxy_q [16];
	logic [3:0]              widx_s1;
	logic signed [MUL_W-1:0] mult_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [15:0]      pix_q;
	logic [1:0]              band_q;
	logic                    last_q;

	logic                    accept, ram_we, tap_end, band_last, cub;
	logic [7:0]              wc, hc;
	logic [2:0]              nb;
	axis_t                   ax, ay;
	logic [ADDR_W-1:0]       ram_addr;
	logic [SAMP_W-1:0]       ram_rdata;
	logic signed [16:0]      mul_a;
	logic signed [PRD_W-1:0] mul_b;
	logic signed [MUL_W-1:0] prod;
	logic signed [ACC_W-1:0] rnd;
	logic signed [21:0]      res;
	logic signed [15:0]      sat;

	// Out-of-range sizes act as the nearest legal value.
	assign wc = (width_q == 8'd0) ? 8'd1 : ((width_q > 8'd128) ? 8'd128 : width_q);
	assign hc = (height_q == 8'd0) ? 8'd1 : ((height_q > 8'd128) ? 8'd128 : height_q);
	assign nb = (bands_q == 3'd0) ? 3'd1 : ((bands_q > 3'd4) ? 3'd4 : bands_q);
	assign cub = (mode_q == MODE_CUBIC);

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign ram_we    = accept && !cmd;
	assign tap_end   = (ti_q == nlast_q) && (tj_q == nlast_q);
	assign band_last = ({1'b0, bq_q} == (nb - 3'd1));

	assign ax = axis_setup(lx_q, wc, mode_q);
	assign ay = axis_setup(ly_q, hc, mode_q);

	// Writes go in from the idle state; reads walk the neighborhood taps.
	assign ram_addr = ram_we ? {write_row, write_col, write_band}
		: {tap_coord(basey_q, tj_q, cub, hc), tap_coord(basex_q, ti_q, cub, wc), bq_q};

	trs_ram #(
		.WIDTH(SAMP_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(sample_value),
		.rdata(ram_rdata)
	);

	// The one multiplier serves the fraction powers, the weight products
	// and the sample products in turn.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (rd_v_s1) begin
			mul_a = {ram_rdata[SAMP_W-1], ram_rdata};
			mul_b = wxy_q[widx_s1];
		end else if (state_q == ST_POW) begin
			case (pow_q)
				2'd0: begin
					mul_a = $signed({9'b0, fx_q});
					mul_b = $signed({22'b0, fx_q});
				end
				2'd1: begin
					mul_a = $signed({9'b0, fy_q});
					mul_b = $signed({22'b0, fy_q});
				end
				2'd2: begin
					mul_a = $signed({1'b0, f2x_q});
					mul_b = $signed({22'b0, fx_q});
				end
				default: begin
					mul_a = $signed({1'b0, f2y_q});
					mul_b = $signed({22'b0, fy_q});
				end
			endcase
		end else begin
			mul_a = {wx_q[ti_q][15], wx_q[ti_q]};
			mul_b = {{(PRD_W-16){wy_q[tj_q][15]}}, wy_q[tj_q]};
		end
	end

	assign prod = mul_a * mul_b;

	// Round half up from Q28 and saturate to 16 bits.
	assign rnd = acc_q + (50'sd1 <<< 27);
	assign res = rnd[ACC_W-1:28];
	assign sat = (res > 22'sd32767) ? 16'sd32767
		: ((res < -22'sd32768) ? -16'sd32768 : res[15:0]);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (accept && cmd) state_d = ST_AXIS;
			ST_AXIS:  state_d = ST_POW;
			ST_POW:   if (pow_q == 2'd3) state_d = ST_WGT;
			ST_WGT:   state_d = ST_PROD;
			ST_PROD:  if (tap_end) state_d = inside_q ? ST_TAP : ST_EMIT;
			ST_TAP:   if (tap_end) state_d = ST_DRAIN;
			ST_DRAIN: if (!rd_v_s1 && !mul_v_s2) state_d = ST_EMIT;
			ST_EMIT: begin
				if (band_last) begin
					state_d = ST_IDLE;
				end else begin
					state_d = inside_q ? ST_TAP : ST_EMIT;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			strobe_q <= 1'b0;
			rd_v_s1  <= 1'b0;
			mul_v_s2 <= 1'b0;
			mode_q   <= MODE_NEAREST;
			width_q  <= 8'd128;
			height_q <= 8'd128;
			bands_q  <= 3'd1;
			org_x_q  <= '0;
			org_y_q  <= '0;
			nodata_q <= '0;
		end else begin
			state_q  <= state_d;
			strobe_q <= (state_q == ST_EMIT);
			rd_v_s1  <= (state_q == ST_TAP);
			mul_v_s2 <= rd_v_s1;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MODE:   mode_q <= mode_t'(cfg_data[1:0]);
					REG_WIDTH:  width_q <= cfg_data[7:0];
					REG_HEIGHT: height_q <= cfg_data[7:0];
					REG_BANDS:  bands_q <= cfg_data[2:0];
					REG_ORG_X:  org_x_q <= cfg_data;
					REG_ORG_Y:  org_y_q <= cfg_data;
					REG_NODATA: nodata_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && cmd) begin
			lx_q <= {{2{src_x[23]}}, src_x} - $signed({2'b0, org_x_q, 8'b0});
			ly_q <= {{2{src_y[23]}}, src_y} - $signed({2'b0, org_y_q, 8'b0});
		end

		if (state_q == ST_AXIS) begin
			inside_q <= ax.ok && ay.ok;
			basex_q  <= ax.base;
			basey_q  <= ay.base;
			fx_q     <= ax.frac;
			fy_q     <= ay.frac;
			pow_q    <= '0;
			bq_q     <= '0;
			ti_q     <= '0;
			tj_q     <= '0;
			case (mode_q)
				MODE_BILINEAR: nlast_q <= 2'd1;
				MODE_CUBIC:    nlast_q <= 2'd3;
				default:       nlast_q <= 2'd0;
			endcase
		end

		if (state_q == ST_POW) begin
			pow_q <= pow_q + 2'd1;
			case (pow_q)
				2'd0: f2x_q <= prod[15:0];
				2'd1: f2y_q <= prod[15:0];
				2'd2: f3x_q <= prod[23:0];
				default: f3y_q <= prod[23:0];
			endcase
		end

		if (state_q == ST_WGT) begin
			for (int k = 0; k < 4; k++) begin
				wx_q[k] <= tap_weight(mode_q, fx_q, f2x_q, f3x_q, 2'(k));
				wy_q[k] <= tap_weight(mode_q, fy_q, f2y_q, f3y_q, 2'(k));
			end
		end

		if (state_q == ST_PROD) begin
			wxy_q[{tj_q, ti_q}] <= prod[PRD_W-1:0];
		end

		// Tap walk, shared by the weight products and the sample reads.
		if (state_q == ST_PROD || state_q == ST_TAP) begin
			widx_s1 <= {tj_q, ti_q};
			if (tap_end) begin
				ti_q <= '0;
				tj_q <= '0;
			end else if (ti_q == nlast_q) begin
				ti_q <= '0;
				tj_q <= tj_q + 2'd1;
			end else begin
				ti_q <= ti_q + 2'd1;
			end
		end

		if (rd_v_s1) begin
			mult_q <= prod;
		end

		if (state_q == ST_WGT || state_q == ST_EMIT) begin
			acc_q <= '0;
		end else if (mul_v_s2) begin
			acc_q <= acc_q + {{(ACC_W-MUL_W){mult_q[MUL_W-1]}}, mult_q};
		end

		if (state_q == ST_EMIT) begin
			pix_q  <= inside_q ? sat : nodata_q;
			band_q <= bq_q;
			last_q <= band_last;
			bq_q   <= bq_q + 2'd1;
		end
	end

	assign strobe      = strobe_q;
	assign pixel_value = pix_q;
	assign band_index  = band_q;
	assign last_band   = last_q;

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the tile resampling interpolator
// Fills a small source tile per phase but one, then fires sample queries in
// nearest, bilinear, cubic and the unused mode. A local predictor computes
// the band results of every accepted query and the monitor checks them in order.
// ----------------------------------------------------------------------------
module tb import trs_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;
	localparam int   IDLE_LIMIT = 5000;
	localparam int   SETTLE     = 150;

	typedef struct {
		logic               cmd;
		logic [6:0]         col;
		logic [6:0]         row;
		logic [1:0]         band;
		logic signed [15:0] value;
		logic signed [23:0] x;
		logic signed [23:0] y;
	} tile_item_t;

	typedef struct {
		logic signed [15:0] value;
		logic [1:0]         band;
		logic               last;
	} band_result_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               cmd;
	logic [6:0]         write_col;
	logic [6:0]         write_row;
	logic [1:0]         write_band;
	logic signed [15:0] sample_value;
	logic signed [23:0] src_x;
	logic signed [23:0] src_y;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [15:0]        cfg_data;
	logic               strobe;
	logic signed [15:0] pixel_value;
	logic [1:0]         band_index;
	logic               last_band;

	tile_resample_interpolator_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.write_col(write_col), .write_row(write_row), .write_band(write_band),
		.sample_value(sample_value), .src_x(src_x), .src_y(src_y),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.strobe(strobe), .pixel_value(pixel_value), .band_index(band_index),
		.last_band(last_band)
	);

	// Pending items for the driver and band results still owed by the block.
	tile_item_t   pending_items[$];
	band_result_t pixel_expect[$];
	tile_item_t   cur_item;
	int           fail_count;
	int           burst_left;
	int           gap_left;
	int           idle_cycles;

	// Shadow of the tile store and of the configuration registers.
	logic signed [15:0] shadow_store[65536];
	logic [1:0]         sh_mode;
	logic [7:0]         sh_width;
	logic [7:0]         sh_height;
	logic [2:0]         sh_bands;
	logic [15:0]        sh_org_x;
	logic [15:0]        sh_org_y;
	logic [15:0]        sh_nodata;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Rounded right shift, half up; the arithmetic shift floors.
	function automatic longint round_half_up(input longint v, input int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint sat_sample(input longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic longint clamp_int(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic longint store_read(input longint row, input longint col, input int b);
		return longint'(shadow_store[((row * 128 + col) * 4 + b) % 65536]);
	endfunction

	// Catmull-Rom weights of a Q1.14 fraction, each rounded to Q14.
	function automatic void catmull_weights(input longint u, output longint w[4]);
		longint u2, u3, s2, s1, one;
		u2 = u * u;
		u3 = u2 * u;
		s2 = u2 * 16384;
		s1 = u * (longint'(1) << 28);
		one = longint'(1) << 42;
		w[0] = round_half_up(-u3 + 2 * s2 - s1, 29);
		w[1] = round_half_up(3 * u3 - 5 * s2 + 2 * one, 29);
		w[2] = round_half_up(-3 * u3 + 4 * s2 + s1, 29);
		w[3] = round_half_up(u3 - s2, 29);
	endfunction

	// Applies one accepted item: a write updates the shadow store, a query
	// queues one expected result per band.
	function automatic void resample_point(input tile_item_t it);
		longint wd, ht, lx, ly, v, tx, ty, ix, iy, cx, cy, ix1, iy1, ux, uy, v0, v1, acc;
		longint wx[4], wy[4];
		int nb;
		band_result_t r;
		if (it.cmd == CMD_WRITE) begin
			shadow_store[{it.row, it.col, it.band}] = it.value;
			return;
		end
		wd = clamp_int(sh_width, 1, 128);
		ht = clamp_int(sh_height, 1, 128);
		nb = int'(clamp_int(sh_bands, 1, 4));
		lx = longint'(it.x) - (longint'(sh_org_x) << 8);
		ly = longint'(it.y) - (longint'(sh_org_y) << 8);
		for (int b = 0; b < nb; b++) begin
			v = longint'($signed(sh_nodata));
			if (sh_mode == MODE_NEAREST) begin
				tx = lx + 128;
				ty = ly + 128;
				ix = (tx >= 0) ? (tx >>> 8) : -((-tx) >>> 8);
				iy = (ty >= 0) ? (ty >>> 8) : -((-ty) >>> 8);
				if (ix >= 0 && ix < wd && iy >= 0 && iy < ht)
					v = store_read(iy, ix, b);
			end else if (sh_mode == MODE_BILINEAR) begin
				if (lx >= -128 && ly >= -128 && lx < wd * 256 + 128 && ly < ht * 256 + 128) begin
					cx = clamp_int(lx, 0, (wd - 1) * 256 - 1);
					cy = clamp_int(ly, 0, (ht - 1) * 256 - 1);
					if (cx < 0) cx = 0;
					if (cy < 0) cy = 0;
					ix = cx >>> 8;
					iy = cy >>> 8;
					ix1 = (ix + 1 < wd - 1) ? ix + 1 : wd - 1;
					iy1 = (iy + 1 < ht - 1) ? iy + 1 : ht - 1;
					ux = (cx - ix * 256) << 6;
					uy = (cy - iy * 256) << 6;
					v0 = store_read(iy, ix, b) * (16384 - ux) + store_read(iy, ix1, b) * ux;
					v1 = store_read(iy1, ix, b) * (16384 - ux) + store_read(iy1, ix1, b) * ux;
					v = sat_sample(round_half_up(v0 * (16384 - uy) + v1 * uy, 28));
				end
			end else if (sh_mode == MODE_CUBIC) begin
				if (lx >= 0 && ly >= 0 && lx <= (wd - 1) * 256 && ly <= (ht - 1) * 256) begin
					ix = lx >>> 8;
					iy = ly >>> 8;
					catmull_weights((lx - ix * 256) << 6, wx);
					catmull_weights((ly - iy * 256) << 6, wy);
					acc = 0;
					for (int j = 0; j < 4; j++)
						for (int i = 0; i < 4; i++)
							acc += store_read(clamp_int(iy + j - 1, 0, ht - 1),
								clamp_int(ix + i - 1, 0, wd - 1), b) * wx[i] * wy[j];
					v = sat_sample(round_half_up(acc, 28));
				end
			end
			r.value = v[15:0];
			r.band = b[1:0];
			r.last = (b == nb - 1);
			pixel_expect.push_back(r);
		end
	endfunction

	// Driver: issues queued items in bursts separated by random gaps. The
	// start line is only updated once a held item is taken, so none is dropped.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cmd <= CMD_WRITE;
			write_col <= '0;
			write_row <= '0;
			write_band <= '0;
			sample_value <= '0;
			src_x <= '0;
			src_y <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (start && !busy)
				resample_point(cur_item);
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pending_items.size() > 0) begin
					cur_item = pending_items.pop_front();
					start <= 1'b1;
					cmd <= cur_item.cmd;
					write_col <= cur_item.col;
					write_row <= cur_item.row;
					write_band <= cur_item.band;
					sample_value <= cur_item.value;
					src_x <= cur_item.x;
					src_y <= cur_item.y;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 16);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every strobe must match the oldest expected band result.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || strobe)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("simulation failed");
				$finish;
			end else if (strobe) begin
				if (pixel_expect.size() == 0) begin
					$error("unexpected result: pixel_value %0d band_index %0d",
						pixel_value, band_index);
					fail_count++;
				end else begin
					band_result_t e;
					e = pixel_expect.pop_front();
					if (pixel_value !== e.value) begin
						$error("pixel_value expected %0d actual %0d", e.value, pixel_value);
						fail_count++;
					end
					if (band_index !== e.band) begin
						$error("band_index expected %0d actual %0d", e.band, band_index);
						fail_count++;
					end
					if (last_band !== e.last) begin
						$error("last_band expected %0d actual %0d", e.last, last_band);
						fail_count++;
					end
				end
			end
		end
	end

	// Register write through the plain write port; the shadow follows at once,
	// which is safe because writes only happen while the block is idle.
	task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_MODE:   sh_mode = data[1:0];
			REG_WIDTH:  sh_width = data[7:0];
			REG_HEIGHT: sh_height = data[7:0];
			REG_BANDS:  sh_bands = data[2:0];
			REG_ORG_X:  sh_org_x = data;
			REG_ORG_Y:  sh_org_y = data;
			default:    sh_nodata = data;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_data <= 16'($urandom());
	endtask

	task automatic setup_phase(input mode_t m, input int wd, input int ht, input int bands,
		input int ox, input int oy, input int nod);
		write_reg(REG_MODE, 16'(m));
		write_reg(REG_WIDTH, 16'(wd));
		write_reg(REG_HEIGHT, 16'(ht));
		write_reg(REG_BANDS, 16'(bands));
		write_reg(REG_ORG_X, 16'(ox));
		write_reg(REG_ORG_Y, 16'(oy));
		write_reg(REG_NODATA, 16'(nod));
	endtask

	function automatic logic signed [15:0] pick_sample();
		case ($urandom_range(0, 5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic tile_item_t make_write(input int row, input int col, input int band);
		tile_item_t it;
		it.cmd = CMD_WRITE;
		it.row = 7'(row);
		it.col = 7'(col);
		it.band = 2'(band);
		it.value = pick_sample();
		it.x = 24'($urandom());
		it.y = 24'($urandom());
		return it;
	endfunction

	// Fills every sample that the current region and band count can read, so
	// no query ever touches an entry that was never written.
	task automatic fill_region();
		int wd, ht, nb;
		wd = int'(clamp_int(sh_width, 1, 128));
		ht = int'(clamp_int(sh_height, 1, 128));
		nb = int'(clamp_int(sh_bands, 1, 4));
		for (int r = 0; r < ht; r++)
			for (int c = 0; c < wd; c++)
				for (int b = 0; b < nb; b++)
					pending_items.push_back(make_write(r, c, b));
	endtask

	// Query at a local position given in 1/256 pixel, made global here.
	task automatic push_query(input longint lx, input longint ly);
		tile_item_t it;
		it = make_write($urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 3));
		it.cmd = CMD_SAMPLE;
		it.x = 24'(lx + (longint'(sh_org_x) << 8));
		it.y = 24'(ly + (longint'(sh_org_y) << 8));
		pending_items.push_back(it);
	endtask

	task automatic push_raw_query(input logic [23:0] x, input logic [23:0] y);
		tile_item_t it;
		it = make_write(0, 0, 0);
		it.cmd = CMD_SAMPLE;
		it.x = x;
		it.y = y;
		pending_items.push_back(it);
	endtask

	// Random queries clustered around the tile, with its edges and a little
	// noise: stray writes anywhere in the store and far-off coordinates.
	task automatic random_queries(input int count);
		longint wd, ht;
		wd = clamp_int(sh_width, 1, 128);
		ht = clamp_int(sh_height, 1, 128);
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(0, 9))
				0: push_raw_query(24'($urandom()), 24'($urandom()));
				1: pending_items.push_back(make_write($urandom_range(0, 127),
					$urandom_range(0, 127), $urandom_range(0, 3)));
				2: push_query($urandom_range(0, 1) * (wd - 1) * 256,
					$urandom_range(0, 1) * (ht - 1) * 256);
				default: push_query(longint'($urandom_range(0, (wd + 2) * 256)) - 384,
					longint'($urandom_range(0, (ht + 2) * 256)) - 384);
			endcase
		end
	endtask

	// Waits until every item is taken and every result has come, then lets
	// the block finish any write still in flight.
	task automatic drain();
		do @(posedge clk);
		while (pending_items.size() != 0 || start || pixel_expect.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		fail_count = 0;
		idle_cycles = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_MODE;
		cfg_data = '0;
		sh_mode = MODE_NEAREST;
		sh_width = 8'd128;
		sh_height = 8'd128;
		sh_bands = 3'd1;
		sh_org_x = '0;
		sh_org_y = '0;
		sh_nodata = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed nearest: corners, the half-pixel rounding edges, truncation
		// toward zero just left of the tile, and the coordinate extremes.
		setup_phase(MODE_NEAREST, 3, 2, 2, 10, 20, 16'h8000);
		fill_region();
		push_query(0, 0);
		push_query(2 * 256 + 127, 1 * 256 + 127);
		push_query(2 * 256 + 128, 0);
		push_query(-128, -128);
		push_query(-129, 0);
		push_query(-383, 100);
		push_raw_query(24'h800000, 24'h7fffff);
		push_raw_query(24'h7fffff, 24'h800000);
		drain();

		// Directed bilinear: the half-pixel margins on both sides and the
		// clamp of the last column and row.
		setup_phase(MODE_BILINEAR, 3, 2, 1, 0, 0, 16'h7fff);
		fill_region();
		push_query(-128, -128);
		push_query(-129, 0);
		push_query(3 * 256 + 127, 2 * 256 + 127);
		push_query(3 * 256 + 128, 0);
		push_query(2 * 256, 1 * 256);
		push_query(255, 511);
		drain();

		// Directed cubic: the exact far edge, one step beyond it, interior
		// fractions and the clamped neighborhood at the near edge.
		setup_phase(MODE_CUBIC, 4, 3, 2, 300, 7, 1234);
		fill_region();
		push_query(3 * 256, 2 * 256);
		push_query(3 * 256 + 1, 0);
		push_query(-1, 0);
		push_query(1, 255);
		push_query(640, 384);
		drain();

		// Unused mode, zero width acting as one, oversize height and band
		// count. No sample is read in this mode, so the tile is not filled.
		setup_phase(MODE_NONE, 0, 255, 7, 0, 0, 16'h5a5a);
		random_queries(6);
		drain();

		// Narrow tiles, far origins and a run of random settings.
		setup_phase(MODE_BILINEAR, 1, 3, 1, 0, 65535, 16'h8000);
		fill_region();
		random_queries(6);
		drain();
		setup_phase(MODE_CUBIC, 5, 1, 1, 0, 0, 16'h0001);
		fill_region();
		random_queries(6);
		drain();
		setup_phase(MODE_NEAREST, 0, 0, 0, 1, 1, 16'h0000);
		fill_region();
		random_queries(6);
		drain();
		for (int p = 0; p < 3; p++) begin
			setup_phase(mode_t'($urandom_range(0, 2)), $urandom_range(1, 3),
				$urandom_range(1, 3), $urandom_range(1, 2), $urandom_range(0, 30000),
				$urandom_range(0, 30000), $urandom());
			fill_region();
			random_queries(8);
			drain();
		end

		if (fail_count == 0 && pixel_expect.size() == 0) begin
			$display("simulation ok");
		end else begin
			if (pixel_expect.size() != 0)
				$error("%0d expected results never arrived", pixel_expect.size());
			$display("simulation failed");
		end
		$finish;
	end

endmodule

>>> tile_resample_interpolator_top.f
design/trs_pkg.sv
design/trs_ram.sv
design/tile_resample_interpolator_top.sv
tb/tb.sv
